// ===== hw/rtl/kt_pkg.sv =====
// ----------------------------------------------------------------------------
// kt_pkg
// Shared types, token codes, keyword table and byte classification for the
// keyword tokenizer.
// ----------------------------------------------------------------------------
package kt_pkg;

  // Default identifier cap and fixed sizes
  localparam int unsigned MAX_IDENT_LEN_DEF = 64;
  localparam int unsigned KW_COUNT          = 14;
  localparam int unsigned CHUNK_BYTES       = 8;
  localparam int unsigned LEN_PORT_W        = 7;
  localparam int unsigned KW_IDX_W          = 4;

  // Token kinds
  localparam logic [4:0] KIND_END       = 5'd0;
  localparam logic [4:0] KIND_ADD       = 5'd1;
  localparam logic [4:0] KIND_SUB       = 5'd2;
  localparam logic [4:0] KIND_CARET     = 5'd3;
  localparam logic [4:0] KIND_EQUAL     = 5'd4;
  localparam logic [4:0] KIND_LESS      = 5'd5;
  localparam logic [4:0] KIND_GREATER   = 5'd6;
  localparam logic [4:0] KIND_LBRACKET  = 5'd7;
  localparam logic [4:0] KIND_RBRACKET  = 5'd8;
  localparam logic [4:0] KIND_SEMICOLON = 5'd9;
  localparam logic [4:0] KIND_COLON     = 5'd10;
  localparam logic [4:0] KIND_NUMBER    = 5'd11;
  localparam logic [4:0] KIND_SYMBOL    = 5'd12;
  localparam logic [4:0] KIND_KW_BASE   = 5'd13;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_CHUNK,
    ST_TAIL
  } fsm_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT
  } mode_e;

  // One result transaction
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] num;
    logic [6:0]  len;
    logic        is_chunk;
    logic [63:0] chunk;
    logic        last;
  } res_t;

  // What one byte means when it is seen outside a pending token
  typedef struct packed {
    logic       has_tok;
    logic [4:0] kind;
    logic       start_num;
    logic       start_ident;
    logic       id_char;
    logic [3:0] digit;
    logic [7:0] up;
  } cls_t;

  // Keyword matcher controls
  typedef struct packed {
    logic       start;
    logic       upd;
    logic [7:0] ch;
  } kw_ctl_t;

  function automatic cls_t classify(input logic [7:0] ch, input logic eoi);
    cls_t c;
    c       = '0;
    c.up    = ch;
    c.digit = ch[3:0];
    if (eoi) begin
      c.has_tok = 1'b1;
      c.kind    = KIND_END;
    end else if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) begin
      c.has_tok = 1'b0;
    end else if (ch >= "0" && ch <= "9") begin
      c.start_num = 1'b1;
      c.id_char   = 1'b1;
    end else if (ch >= "A" && ch <= "Z") begin
      c.start_ident = 1'b1;
      c.id_char     = 1'b1;
    end else if (ch >= "a" && ch <= "z") begin
      c.start_ident = 1'b1;
      c.id_char     = 1'b1;
      c.up          = ch - 8'd32;
    end else if (ch == "_") begin
      // underscore only continues an identifier; alone it is unrecognized
      c.id_char = 1'b1;
      c.has_tok = 1'b1;
      c.kind    = KIND_END;
    end else begin
      c.has_tok = 1'b1;
      case (ch)
        "+":      c.kind = KIND_ADD;
        "-":      c.kind = KIND_SUB;
        "^":      c.kind = KIND_CARET;
        "=":      c.kind = KIND_EQUAL;
        "<":      c.kind = KIND_LESS;
        ">":      c.kind = KIND_GREATER;
        "[", "(": c.kind = KIND_LBRACKET;
        "]", ")": c.kind = KIND_RBRACKET;
        ";":      c.kind = KIND_SEMICOLON;
        ":":      c.kind = KIND_COLON;
        default:  c.kind = KIND_END;
      endcase
    end
    return c;
  endfunction

  // Keyword text, first character in the highest used byte
  function automatic logic [71:0] kw_text(input logic [KW_IDX_W-1:0] idx);
    logic [71:0] w;
    case (idx)
      4'd0:    w = 72'("IF");
      4'd1:    w = 72'("ELSE");
      4'd2:    w = 72'("WHILE");
      4'd3:    w = 72'("BEGIN");
      4'd4:    w = 72'("END");
      4'd5:    w = 72'("PROCEDURE");
      4'd6:    w = 72'("DEFINE");
      4'd7:    w = 72'("SET");
      4'd8:    w = 72'("AND");
      4'd9:    w = 72'("XOR");
      4'd10:   w = 72'("OR");
      4'd11:   w = 72'("INTEGER");
      4'd12:   w = 72'("CHAR");
      4'd13:   w = 72'("RETURN");
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [KW_IDX_W-1:0] idx);
    logic [3:0] l;
    case (idx)
      4'd0:    l = 4'd2;
      4'd1:    l = 4'd4;
      4'd2:    l = 4'd5;
      4'd3:    l = 4'd5;
      4'd4:    l = 4'd3;
      4'd5:    l = 4'd9;
      4'd6:    l = 4'd6;
      4'd7:    l = 4'd3;
      4'd8:    l = 4'd3;
      4'd9:    l = 4'd3;
      4'd10:   l = 4'd2;
      4'd11:   l = 4'd7;
      4'd12:   l = 4'd4;
      4'd13:   l = 4'd6;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Character of a keyword at a position, zero past its end
  function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] idx,
                                         input logic [6:0] pos);
    logic [71:0] w;
    logic [3:0]  l;
    logic [7:0]  c;
    w = kw_text(idx);
    l = kw_len(idx);
    c = '0;
    if (pos < 7'(l)) begin
      c = w[8*(int'(l) - 1 - int'(pos)) +: 8];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/kt_ident_mem.sv =====
// ----------------------------------------------------------------------------
// kt_ident_mem
// Identifier text store: rows of eight bytes, byte-lane writes, one
// registered row read per cycle.
// ----------------------------------------------------------------------------
module kt_ident_mem #(
  parameter int unsigned ROWS  = 8,
  parameter int unsigned ROW_W = 3
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [ROW_W-1:0] wr_row_i,
  input  logic [2:0]       wr_lane_i,
  input  logic [7:0]       wr_byte_i,
  input  logic [ROW_W-1:0] rd_row_i,
  output logic [63:0]      rd_data_o
);

  logic [63:0] mem [ROWS];
  logic [63:0] rd_data_q;

  // Write one byte lane of a row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i][8*wr_lane_i +: 8] <= wr_byte_i;
    end
  end

  // Read one row, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_row_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/kt_kw_match.sv =====
// ----------------------------------------------------------------------------
// kt_kw_match
// Running keyword match: one candidate bit per keyword, narrowed as each
// identifier character is stored, checked against length at the end.
// ----------------------------------------------------------------------------
module kt_kw_match #(
  parameter int unsigned LEN_W = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kt_pkg::kw_ctl_t               ctl_i,
  input  logic [LEN_W-1:0]              pos_i,
  input  logic [LEN_W-1:0]              len_i,
  output logic                          hit_o,
  output logic [kt_pkg::KW_IDX_W-1:0]   idx_o
);

  logic [kt_pkg::KW_COUNT-1:0] mask_q, mask_d;

  // Narrow candidates with the new character
  always_comb begin
    mask_d = mask_q;
    for (int i = 0; i < kt_pkg::KW_COUNT; i++) begin
      if (ctl_i.start) begin
        mask_d[i] = (kt_pkg::kw_char(kt_pkg::KW_IDX_W'(i), 7'd0) == ctl_i.ch);
      end else if (ctl_i.upd) begin
        mask_d[i] = mask_q[i] &&
                    (kt_pkg::kw_char(kt_pkg::KW_IDX_W'(i), 7'(pos_i)) == ctl_i.ch);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Keywords are distinct, so at most one candidate survives the length check
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = 0; i < kt_pkg::KW_COUNT; i++) begin
      if (mask_q[i] && (7'(len_i) == 7'(kt_pkg::kw_len(kt_pkg::KW_IDX_W'(i))))) begin
        hit_o = 1'b1;
        idx_o = idx_o | kt_pkg::KW_IDX_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/kt_out_reg.sv =====
// ----------------------------------------------------------------------------
// kt_out_reg
// Result output register: holds one result transaction until it is taken.
// ----------------------------------------------------------------------------
module kt_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  kt_pkg::res_t  in_data_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kt_pkg::res_t  out_data_o
);

  logic         valid_q;
  kt_pkg::res_t data_q;

  // Free when empty or when the held result leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/keyword_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// keyword_tokenizer_unit
// Streaming tokenizer: source bytes in, operator, number, keyword and symbol
// tokens out, with symbol text in eight-byte chunks.
// ----------------------------------------------------------------------------
// Rate: one byte per cycle in the scan state while the output register is free.
// A byte that ends a number or keyword and also gives its own token holds off
// the next byte until that token is sent from the tail state. A byte that ends
// a non-keyword identifier of length L holds off the next byte until ceil(L/8)
// chunks and any own token are out; the chunk burst is paced by the identifier
// memory, which yields one eight-byte row per cycle. Keyword matching is done
// as characters arrive. The identifier memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module keyword_tokenizer_unit #(
  parameter int unsigned MAX_IDENT_LEN = kt_pkg::MAX_IDENT_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] number_value_o,
  output logic [6:0]  text_length_o,
  output logic        is_chunk_o,
  output logic [63:0] text_chunk_o,
  output logic        last_o
);

  localparam int unsigned LEN_W = $clog2(MAX_IDENT_LEN + 1);
  localparam int unsigned ROWS  = (MAX_IDENT_LEN + kt_pkg::CHUNK_BYTES - 1) /
                                  kt_pkg::CHUNK_BYTES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  kt_pkg::fsm_e    state_q, state_d;
  kt_pkg::mode_e   mode_q, mode_d;
  logic [31:0]     acc_q, acc_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [7:0]      term_char_q, term_char_d;
  logic            term_end_q, term_end_d;
  logic [4:0]      tail_kind_q, tail_kind_d;

  logic            slot_free;
  logic            res_valid;
  kt_pkg::res_t    res;
  kt_pkg::res_t    out_data;

  logic            wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [2:0]      wr_lane;
  logic [7:0]      wr_byte;
  logic [63:0]     rd_data;

  kt_pkg::kw_ctl_t kw_ctl;
  logic [LEN_W-1:0] kw_pos;
  logic            kw_hit;
  logic [kt_pkg::KW_IDX_W-1:0] kw_idx;

  logic [7:0]      src_char;
  logic            src_end;
  kt_pkg::cls_t    cls;
  logic            in_fire;
  logic            cont_num;
  logic            cont_id;
  logic [31:0]     acc_x10;
  logic [LEN_W-1:0] len_m1;
  logic            chunk_last;
  logic [63:0]     chunk_data;
  logic            apply_start;
  logic            apply_tail;

  // Byte under decision: the incoming one, or the held terminator after chunks
  assign src_char = (state_q == kt_pkg::ST_CHUNK) ? term_char_q : char_in_i;
  assign src_end  = (state_q == kt_pkg::ST_CHUNK) ? term_end_q  : end_of_input_i;
  assign cls      = kt_pkg::classify(src_char, src_end);

  assign in_fire  = in_valid_i && slot_free && (state_q == kt_pkg::ST_SCAN);
  assign cont_num = (mode_q == kt_pkg::MODE_NUM) && !end_of_input_i && cls.start_num;
  assign cont_id  = (mode_q == kt_pkg::MODE_IDENT) && !end_of_input_i && cls.id_char &&
                    (len_q < LEN_W'(MAX_IDENT_LEN));
  assign acc_x10  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, cls.digit};

  // Chunk bookkeeping
  assign len_m1     = len_q - LEN_W'(1);
  assign chunk_last = (row_q == len_m1[ROW_W+2:3]);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      chunk_data[8*b +: 8] = (LEN_W'({row_q, 3'(b)}) < len_q) ? rd_data[8*b +: 8] : 8'd0;
    end
  end

  // Sequencer: next state, memory and matcher controls, result
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    acc_d       = acc_q;
    len_d       = len_q;
    row_d       = row_q;
    term_char_d = term_char_q;
    term_end_d  = term_end_q;
    tail_kind_d = tail_kind_q;
    in_ready_o  = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    wr_en       = 1'b0;
    wr_row      = len_q[ROW_W+2:3];
    wr_lane     = len_q[2:0];
    wr_byte     = cls.up;
    kw_ctl      = '0;
    kw_ctl.ch   = cls.up;
    kw_pos      = len_q;
    apply_start = 1'b0;
    apply_tail  = 1'b0;

    case (state_q)
      kt_pkg::ST_SCAN: begin
        in_ready_o = slot_free;
        if (in_fire) begin
          if (cont_num) begin
            acc_d = acc_x10;
          end else if (cont_id) begin
            wr_en      = 1'b1;
            kw_ctl.upd = 1'b1;
            len_d      = len_q + LEN_W'(1);
          end else begin
            case (mode_q)
              kt_pkg::MODE_NUM: begin
                res_valid   = 1'b1;
                res.kind    = kt_pkg::KIND_NUMBER;
                res.num     = acc_q;
                res.last    = !cls.has_tok;
                apply_start = 1'b1;
                apply_tail  = 1'b1;
              end
              kt_pkg::MODE_IDENT: begin
                res_valid = 1'b1;
                if (kw_hit) begin
                  res.kind    = kt_pkg::KIND_KW_BASE + 5'(kw_idx);
                  res.last    = !cls.has_tok;
                  apply_start = 1'b1;
                  apply_tail  = 1'b1;
                end else begin
                  // Hold the terminator until the text is out
                  res.kind    = kt_pkg::KIND_SYMBOL;
                  res.len     = 7'(len_q);
                  term_char_d = char_in_i;
                  term_end_d  = end_of_input_i;
                  row_d       = '0;
                  state_d     = kt_pkg::ST_CHUNK;
                end
              end
              default: begin
                res_valid   = cls.has_tok;
                res.kind    = cls.kind;
                res.last    = 1'b1;
                apply_start = 1'b1;
              end
            endcase
          end
        end
      end
      kt_pkg::ST_CHUNK: begin
        if (slot_free) begin
          res_valid    = 1'b1;
          res.kind     = kt_pkg::KIND_SYMBOL;
          res.is_chunk = 1'b1;
          res.chunk    = chunk_data;
          res.last     = chunk_last && !cls.has_tok;
          row_d        = row_q + ROW_W'(1);
          if (chunk_last) begin
            apply_start = 1'b1;
            apply_tail  = 1'b1;
          end
        end
      end
      kt_pkg::ST_TAIL: begin
        if (slot_free) begin
          res_valid = 1'b1;
          res.kind  = tail_kind_q;
          res.last  = 1'b1;
          state_d   = kt_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = kt_pkg::ST_SCAN;
      end
    endcase

    // Start whatever the decided byte opens
    if (apply_start) begin
      mode_d = kt_pkg::MODE_IDLE;
      if (cls.start_num) begin
        acc_d  = {28'd0, cls.digit};
        mode_d = kt_pkg::MODE_NUM;
      end else if (cls.start_ident) begin
        wr_en        = 1'b1;
        wr_row       = '0;
        wr_lane      = 3'd0;
        kw_ctl.start = 1'b1;
        len_d        = LEN_W'(1);
        mode_d       = kt_pkg::MODE_IDENT;
      end
    end

    // Queue the byte's own token behind the pending one
    if (apply_tail) begin
      tail_kind_d = cls.kind;
      state_d     = cls.has_tok ? kt_pkg::ST_TAIL : kt_pkg::ST_SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kt_pkg::ST_SCAN;
      mode_q  <= kt_pkg::MODE_IDLE;
      acc_q   <= '0;
      len_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_char_q <= term_char_d;
    term_end_q  <= term_end_d;
    tail_kind_q <= tail_kind_d;
  end

  // Identifier text; the read row follows the next chunk row
  kt_ident_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_lane_i (wr_lane),
    .wr_byte_i (wr_byte),
    .rd_row_i  (row_d),
    .rd_data_o (rd_data)
  );

  kt_kw_match #(
    .LEN_W (LEN_W)
  ) u_kw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (kw_ctl),
    .pos_i  (kw_pos),
    .len_i  (len_q),
    .hit_o  (kw_hit),
    .idx_o  (kw_idx)
  );

  kt_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign token_kind_o   = out_data.kind;
  assign number_value_o = out_data.num;
  assign text_length_o  = out_data.len;
  assign is_chunk_o     = out_data.is_chunk;
  assign text_chunk_o   = out_data.chunk;
  assign last_o         = out_data.last;

endmodule

// ===== hw/rtl/kt_checker.sv =====
// ----------------------------------------------------------------------------
// kt_checker
// Port-level checks on the tokenizer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module kt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_o,
  input logic [31:0] number_value_o,
  input logic [6:0]  text_length_o,
  input logic        is_chunk_o,
  input logic [63:0] text_chunk_o,
  input logic        last_o
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(text_chunk_o) && $stable(number_value_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Chunks are plain symbol text
  a_chunk_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_chunk_o |-> token_kind_o == kt_pkg::KIND_SYMBOL &&
    number_value_o == 32'd0 && text_length_o == 7'd0)
    else $error("malformed chunk result");

  // A symbol header always has text after it
  a_symbol_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_chunk_o && token_kind_o == kt_pkg::KIND_SYMBOL |->
    !last_o && text_length_o != 7'd0)
    else $error("symbol header closed the transaction group");

  // Only number tokens carry a value
  a_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != kt_pkg::KIND_NUMBER |-> number_value_o == 32'd0)
    else $error("value on a non-number token");

  // Only symbol headers carry a length
  a_len_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_length_o != 7'd0 |->
    token_kind_o == kt_pkg::KIND_SYMBOL && !is_chunk_o)
    else $error("length on a non-symbol result");

endmodule

bind keyword_tokenizer_unit kt_checker u_kt_checker (.*);

// ===== tb/sv/tb_keyword_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_keyword_tokenizer_unit
// Self-checking bench for the keyword tokenizer. Directed operator, number,
// identifier and odd-byte text comes first. Random token streams follow:
// keywords in mixed case, identifiers up to past the length cap, wrapping
// numbers, operators, whitespace, stray bytes and end-of-input marks. A local
// scanner predicts every token transaction, and the monitor compares each
// field. Both sides insert random idle cycles, with bursts of no idling.
// ----------------------------------------------------------------------------
module tb_keyword_tokenizer_unit;

  localparam int unsigned IDENT_CAP   = kt_pkg::MAX_IDENT_LEN_DEF;
  localparam int unsigned TEXT_BYTES  = 180;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_TAIL  = 24;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  // DUT connections
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_in_i      = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [4:0]  token_kind_o;
  logic [31:0] number_value_o;
  logic [6:0]  text_length_o;
  logic        is_chunk_o;
  logic [63:0] text_chunk_o;
  logic        last_o;

  // Source text and expected tokens
  src_byte_t      src_q[$];
  src_byte_t      next_byte;
  kt_pkg::res_t   token_q[$];

  // Scanner state of the predictor
  kt_pkg::mode_e  lex_mode = kt_pkg::MODE_IDLE;
  logic [31:0]    num_acc  = '0;
  logic [7:0]     id_buf [IDENT_CAP];
  int unsigned    id_len   = 0;

  string kw_word [14] = '{"IF", "ELSE", "WHILE", "BEGIN", "END", "PROCEDURE", "DEFINE",
                          "SET", "AND", "XOR", "OR", "INTEGER", "CHAR", "RETURN"};

  int unsigned in_wait     = 0;
  int unsigned out_wait    = 0;
  bit          in_burst    = 1'b0;
  bit          out_burst   = 1'b0;
  int unsigned err_cnt     = 0;
  int unsigned idle_cycles = 0;

  keyword_tokenizer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .number_value_o (number_value_o),
    .text_length_o  (text_length_o),
    .is_chunk_o     (is_chunk_o),
    .text_chunk_o   (text_chunk_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [4:0] operator_kind(input logic [7:0] ch);
    case (ch)
      "+":      return kt_pkg::KIND_ADD;
      "-":      return kt_pkg::KIND_SUB;
      "^":      return kt_pkg::KIND_CARET;
      "=":      return kt_pkg::KIND_EQUAL;
      "<":      return kt_pkg::KIND_LESS;
      ">":      return kt_pkg::KIND_GREATER;
      "[", "(": return kt_pkg::KIND_LBRACKET;
      "]", ")": return kt_pkg::KIND_RBRACKET;
      ";":      return kt_pkg::KIND_SEMICOLON;
      ":":      return kt_pkg::KIND_COLON;
      default:  return kt_pkg::KIND_END;
    endcase
  endfunction

  task automatic push_token(input logic [4:0] kind, input logic [31:0] num,
                            input logic [6:0] len, input logic chunk_flag,
                            input logic [63:0] chunk);
    kt_pkg::res_t tok;
    tok.kind     = kind;
    tok.num      = num;
    tok.len      = len;
    tok.is_chunk = chunk_flag;
    tok.chunk    = chunk;
    tok.last     = 1'b0;
    token_q.push_back(tok);
  endtask

  // Emit a keyword token, or a symbol token with its text in 8-byte chunks
  task automatic flush_ident();
    int unsigned k;
    int unsigned j;
    int unsigned pos;
    bit          hit;
    logic [63:0] word;
    for (k = 0; k < 14; k++) begin
      if (kw_word[k].len() == id_len) begin
        hit = 1'b1;
        for (j = 0; j < id_len; j++) begin
          if (kw_word[k][j] != id_buf[j]) hit = 1'b0;
        end
        if (hit) begin
          push_token(kt_pkg::KIND_KW_BASE + 5'(k), '0, '0, 1'b0, '0);
          return;
        end
      end
    end
    push_token(kt_pkg::KIND_SYMBOL, '0, 7'(id_len), 1'b0, '0);
    for (pos = 0; pos < id_len; pos += 8) begin
      word = '0;
      for (j = 0; j < 8 && pos + j < id_len; j++) begin
        word[8*j +: 8] = id_buf[pos + j];
      end
      push_token(kt_pkg::KIND_SYMBOL, '0, '0, 1'b1, word);
    end
  endtask

  // Advance the scanner by one source byte and queue the tokens it releases
  task automatic tokenize_byte(input logic [7:0] ch, input logic eoi);
    int unsigned  first;
    logic         is_dig;
    logic         is_low;
    logic         is_let;
    logic [4:0]   op;
    logic [7:0]   up;
    kt_pkg::res_t tail;
    first  = token_q.size();
    is_dig = (ch >= "0" && ch <= "9");
    is_low = (ch >= "a" && ch <= "z");
    is_let = is_low || (ch >= "A" && ch <= "Z");
    up     = is_low ? ch - 8'd32 : ch;
    op     = operator_kind(ch);

    // Extend a pending number or identifier, or close it
    if (lex_mode == kt_pkg::MODE_NUM) begin
      if (!eoi && is_dig) begin
        num_acc = num_acc * 32'd10 + 32'(ch - 8'h30);
        return;
      end
      push_token(kt_pkg::KIND_NUMBER, num_acc, '0, 1'b0, '0);
    end else if (lex_mode == kt_pkg::MODE_IDENT) begin
      if (!eoi && id_len < IDENT_CAP && (is_let || is_dig || ch == "_")) begin
        id_buf[id_len] = up;
        id_len++;
        return;
      end
      flush_ident();
    end
    lex_mode = kt_pkg::MODE_IDLE;

    // Handle the byte as the start of a new token
    if (eoi) begin
      push_token(kt_pkg::KIND_END, '0, '0, 1'b0, '0);
    end else if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) begin
      // whitespace gives nothing
    end else if (op != kt_pkg::KIND_END) begin
      push_token(op, '0, '0, 1'b0, '0);
    end else if (is_dig) begin
      num_acc  = 32'(ch - 8'h30);
      lex_mode = kt_pkg::MODE_NUM;
    end else if (is_let) begin
      id_buf[0] = up;
      id_len    = 1;
      lex_mode  = kt_pkg::MODE_IDENT;
    end else begin
      push_token(kt_pkg::KIND_END, '0, '0, 1'b0, '0);
    end

    // Flag the final token of this byte
    if (token_q.size() > first) begin
      tail      = token_q.pop_back();
      tail.last = 1'b1;
      token_q.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_char(input logic [7:0] ch);
    src_byte_t b;
    b.ch  = ch;
    b.eoi = 1'b0;
    src_q.push_back(b);
  endtask

  task automatic push_text(input string s);
    int unsigned i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // End of text; the byte lane carries junk that must be ignored
  task automatic push_end();
    src_byte_t b;
    b.ch  = 8'($urandom_range(0, 255));
    b.eoi = 1'b1;
    src_q.push_back(b);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_separator();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 8'd9;
      1:       return 8'd10;
      2:       return 8'd13;
      3:       return "(";
      4:       return ")";
      5:       return ";";
      6:       return "=";
      default: return " ";
    endcase
  endfunction

  task automatic add_ident(input int unsigned len);
    int unsigned i;
    push_char(rand_letter());
    for (i = 1; i < len; i++) push_char(rand_word_char());
  endtask

  // Append one random lexical element, mostly well-formed tokens
  task automatic add_random_token();
    int unsigned r;
    int unsigned i;
    int unsigned k;
    logic [7:0]  c;
    string       ops;
    ops = "+-^=<>[]();:";
    r = $urandom_range(0, 99);
    if (r < 22) begin
      k = $urandom_range(0, 13);
      for (i = 0; i < kw_word[k].len(); i++) begin
        c = kw_word[k][i];
        push_char($urandom_range(0, 1) ? c + 8'd32 : c);
      end
    end else if (r < 42) begin
      add_ident(($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                             : $urandom_range(1, 12));
    end else if (r < 56) begin
      k = $urandom_range(1, 12);
      for (i = 0; i < k; i++) push_char(8'("0" + $urandom_range(0, 9)));
    end else if (r < 72) begin
      k = $urandom_range(0, 11);
      push_char(ops[k]);
    end else if (r < 80) begin
      push_char(rand_separator());
    end else if (r < 92) begin
      push_char(8'($urandom_range(0, 255)));
    end else begin
      push_end();
    end
    // Usually terminate word-like tokens so keywords stay keywords
    if (r >= 10 && r < 56 && $urandom_range(0, 3) != 0) push_char(rand_separator());
  endtask

  task automatic build_source_text();
    // Every operator, whitespace, stray bytes and a lone underscore
    push_text("+-^=<>[(]);: ");
    push_char(8'd9);
    push_char(8'd13);
    push_char("_");
    push_char(8'h00);
    push_char(8'hFF);
    push_char(8'h80);
    // Wrapping number, keyword closed by an operator, pending identifier at end
    push_text("9999999999+if)x_9");
    push_end();
    // Identifier over the cap, then random token streams
    add_ident(66);
    push_char(" ");
    while (src_q.size() < TEXT_BYTES) add_random_token();
    push_end();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present source bytes, predict on each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tokenize_byte(char_in_i, end_of_input_i);
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_wait = in_burst ? 0 : $urandom_range(0, 13);
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_wait == 0 && src_q.size() > 0) begin
          next_byte       = src_q.pop_front();
          char_in_i      <= next_byte.ch;
          end_of_input_i <= next_byte.eoi;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each token transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_token();
    kt_pkg::res_t exp_tok;
    if (token_q.size() == 0) begin
      $error("unexpected token: kind %0d", token_kind_o);
      err_cnt++;
      return;
    end
    exp_tok = token_q.pop_front();
    compare_field("token_kind", 64'(exp_tok.kind), 64'(token_kind_o));
    compare_field("number_value", 64'(exp_tok.num), 64'(number_value_o));
    compare_field("text_length", 64'(exp_tok.len), 64'(text_length_o));
    compare_field("is_chunk", 64'(exp_tok.is_chunk), 64'(is_chunk_o));
    compare_field("text_chunk", exp_tok.chunk, text_chunk_o);
    compare_field("last", 64'(exp_tok.last), 64'(last_o));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_token();
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 13);
      end
      if (out_wait > 0) begin
        out_ready_i <= 1'b0;
        out_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stop the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Reset, run the text through, drain and report
  initial begin
    build_source_text();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (src_q.size() != 0 || in_valid_i || token_q.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
